[hdl/lkt_pkg.sv]
// Shared types, constants and helper functions for the landmark tracker.
// Depends on nothing; every other file imports it.
`default_nettype none
package lkt_pkg;

    localparam int WORD_W     = 32;
    localparam int NOISE_W    = 31;
    localparam int IDX_W      = 7;
    localparam int MEAS_W     = 14;
    localparam int PRED_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_FRAC   = 16;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_NUM_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 31'd168;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd1677722;

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

    // One track entry: both axes share one covariance.
    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] cov_pos;
        logic signed [WORD_W-1:0] cov_cross;
        logic signed [WORD_W-1:0] cov_vel;
    } t_track;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PRED,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_ACC,
        ST_WRITE
    } t_state;

    // Steps of the correction sequence.
    typedef enum logic [3:0] {
        OP_GAIN_POS,
        OP_GAIN_VEL,
        OP_COV_POS,
        OP_COV_CROSS,
        OP_COV_VEL,
        OP_POS_X,
        OP_VEL_X,
        OP_POS_Y,
        OP_VEL_Y
    } t_op;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W:0] v);
        logic signed [WORD_W-1:0] res;
        if (v > (PROD_W+1)'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < (PROD_W+1)'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

    // Apply a sign to an unsigned quotient magnitude and saturate.
    function automatic logic signed [WORD_W-1:0] quot_sat(input logic [WORD_W-1:0] q,
                                                          input logic ovf,
                                                          input logic neg);
        logic signed [WORD_W-1:0] res;
        if (!neg) begin
            res = (ovf || q[WORD_W-1]) ? S32_MAX : $signed(q);
        end else if (ovf || (q[WORD_W-1] && (q[WORD_W-2:0] != '0))) begin
            res = S32_MIN;
        end else begin
            res = $signed(-q);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hdl/lkt_in_if.sv]
// Input channel: one measurement per transfer.
// Depends on lkt_pkg for the field widths.
`default_nettype none
interface lkt_in_if
    import lkt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         landmark_index;
    logic signed [MEAS_W-1:0] meas_x;
    logic signed [MEAS_W-1:0] meas_y;

    modport source (output valid, output landmark_index, output meas_x, output meas_y,
                    input ready);
    modport sink (input valid, input landmark_index, input meas_x, input meas_y,
                  output ready);
endinterface
`default_nettype wire

[hdl/lkt_out_if.sv]
// Output channel: one predicted point per transfer.
// Depends on lkt_pkg for the field widths.
`default_nettype none
interface lkt_out_if
    import lkt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_index;
    logic signed [PRED_W-1:0] pred_x;
    logic signed [PRED_W-1:0] pred_y;

    modport source (output valid, output out_index, output pred_x, output pred_y,
                    input ready);
    modport sink (input valid, input out_index, input pred_x, input pred_y,
                  output ready);
endinterface
`default_nettype wire

[hdl/lkt_track_mem.sv]
// Track state memory: one wide word per landmark, registered read.
// Per-entry valid bits make never-written entries read as the reset track.
`default_nettype none
module lkt_track_mem
    import lkt_pkg::*;
#(
    parameter int LANDMARKS     = 68,
    parameter int COV_FRAC_BITS = 24,
    parameter int AW            = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_idx,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_idx,
    input  wire t_track        i_wr_data,
    output t_track             o_rd_data
);
    t_track             mem [LANDMARKS];
    logic [LANDMARKS-1:0] r_valid;
    t_track             r_rd_data;
    logic               r_rd_valid;
    t_track             rst_word;

    // Reset track: zero state, unit variances.
    always_comb begin
        rst_word           = '0;
        rst_word.cov_pos   = WORD_W'(64'sd1 <<< COV_FRAC_BITS);
        rst_word.cov_vel   = WORD_W'(64'sd1 <<< COV_FRAC_BITS);
    end

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    // Valid bits are control state and clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : rst_word;
endmodule
`default_nettype wire

[hdl/lkt_divider.sv]
// Restoring divider, one quotient bit per cycle, 32-bit quotient magnitude.
// Flags overflow when the quotient would not fit in 32 bits.
`default_nettype none
module lkt_divider
    import lkt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [WORD_W-1:0]    i_den,
    output logic                      o_busy,
    output logic [WORD_W-1:0]         o_quot,
    output logic                      o_ovf
);
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_den;
    logic              r_ovf;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic [WORD_W:0]   trial;
    logic              fits;

    // One shift-and-subtract step.
    assign trial = {r_rem, r_lo[WORD_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_NUM_W-1:WORD_W];
            r_lo  <= i_num[WORD_W-1:0];
            r_den <= i_den;
            r_ovf <= i_num[DIV_NUM_W-1:WORD_W] >= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? WORD_W'(trial - {1'b0, r_den}) : trial[WORD_W-1:0];
            r_lo  <= {r_lo[WORD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(WORD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_busy <= r_cnt != 6'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_lo;
    assign o_ovf  = r_ovf;
endmodule
`default_nettype wire

[hdl/landmark_kalman_tracker.sv]
// Landmark Kalman tracker top level: sequencer, shared multiplier, gains.
// READ and PRED follow the input transfer; PRED loads the predicted point into the
// result register once it is free. Input is taken only when idle; each correction has
// five divide steps and four state updates, none when S <= 0 or for a bad index.
// Synchronous active-low reset restores the noise registers; tracks read as
// the reset state through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module landmark_kalman_tracker
    import lkt_pkg::*;
#(
    parameter int LANDMARKS     = 68,
    parameter int COV_FRAC_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [NOISE_W-1:0]   i_cfg_data,
    lkt_in_if.sink                    i_in,
    lkt_out_if.source                 o_out
);
    localparam int AW = (LANDMARKS > 1) ? $clog2(LANDMARKS) : 1;

    t_state r_state, n_state;
    t_op    r_op;

    logic [NOISE_W-1:0] r_q, r_r;
    logic [IDX_W-1:0]   r_idx;
    logic               r_oor;
    logic signed [MEAS_W-1:0] r_mx, r_my;

    logic signed [WORD_W-1:0] r_px, r_py, r_p00, r_p01, r_p11, r_k0, r_k1;
    logic signed [WORD_W-1:0] r_wpx, r_wpy, r_vx, r_vy, r_c00, r_c01, r_c11;
    logic signed [MUL_W-1:0]  r_ex, r_ey;
    logic [WORD_W-1:0]        r_s;
    logic signed [PROD_W-1:0] r_prod;

    logic               r_ovalid;
    logic [IDX_W-1:0]   r_oidx;
    logic signed [PRED_W-1:0] r_opx, r_opy;

    logic   out_free, in_xfer;
    logic   mem_rd_en, mem_wr_en, div_start;
    t_track rd_data, wr_data;
    logic [8:0] idx_ext;
    logic   div_busy, div_ovf;
    logic [WORD_W-1:0] div_quot;

    logic signed [WORD_W-1:0] p00_n, px_n, py_n, p01_n, p11_n;
    logic signed [PRED_W-1:0] pix_x, pix_y;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign idx_ext  = {2'b00, r_idx};

    // Track memory.
    assign wr_data = '{pos_x: r_wpx, pos_y: r_wpy, vel_x: r_vx, vel_y: r_vy,
                       cov_pos: r_c00, cov_cross: r_c01, cov_vel: r_c11};

    lkt_track_mem #(
        .LANDMARKS     (LANDMARKS),
        .COV_FRAC_BITS (COV_FRAC_BITS),
        .AW            (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_idx  (idx_ext[AW-1:0]),
        .i_wr_en   (mem_wr_en),
        .i_wr_idx  (idx_ext[AW-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Shared divider: numerator magnitude over innovation variance.
    logic                 prod_neg;
    logic [DIV_NUM_W-1:0] prod_mag;
    assign prod_neg = r_prod[PROD_W-1];
    assign prod_mag = prod_neg ? DIV_NUM_W'(-r_prod) : DIV_NUM_W'(r_prod);

    lkt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod_mag),
        .i_den   (r_s),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= PROCESS_NOISE_RST;
            r_r <= MEASURE_NOISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                CFG_MEASURE_NOISE: r_r <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_READ;
            ST_READ:  n_state = ST_PRED;
            ST_PRED: begin
                if (out_free) begin
                    if (r_oor) begin
                        n_state = ST_IDLE;
                    end else if ($signed({p00_n[WORD_W-1], p00_n})
                                 + $signed({2'b00, r_r}) <= 0) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL:   n_state = (r_op <= OP_COV_VEL) ? ST_DIV : ST_ACC;
            ST_DIV:   n_state = ST_WAIT;
            ST_WAIT:  if (!div_busy) n_state = ST_MUL;
            ST_ACC:   n_state = (r_op == OP_VEL_Y) ? ST_WRITE : ST_MUL;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        i_in.ready = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_in.ready = 1'b1;
            ST_READ:  mem_rd_en  = !r_oor;
            ST_DIV:   div_start  = 1'b1;
            ST_WRITE: mem_wr_en  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Predict from the stored track.
    function automatic logic signed [PRED_W-1:0] to_pixels(input logic signed [WORD_W-1:0] p);
        logic signed [WORD_W-POS_FRAC:0] w;
        logic signed [PRED_W-1:0] res;
        w = (WORD_W-POS_FRAC+1)'(p >>> POS_FRAC);
        if (p[WORD_W-1] && (p[POS_FRAC-1:0] != '0)) begin
            w = w + (WORD_W-POS_FRAC+1)'(1);
        end
        if (w > (WORD_W-POS_FRAC+1)'(16383)) begin
            res = 15'sd16383;
        end else if (w < -(WORD_W-POS_FRAC+1)'(16384)) begin
            res = 15'sh4000;
        end else begin
            res = w[PRED_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        px_n  = sat32((PROD_W+1)'(rd_data.pos_x) + (PROD_W+1)'(rd_data.vel_x));
        py_n  = sat32((PROD_W+1)'(rd_data.pos_y) + (PROD_W+1)'(rd_data.vel_y));
        p00_n = sat32((PROD_W+1)'(rd_data.cov_pos)
                      + ((PROD_W+1)'(rd_data.cov_cross) <<< 1)
                      + (PROD_W+1)'(rd_data.cov_vel)
                      + (PROD_W+1)'({1'b0, r_q}));
        p01_n = sat32((PROD_W+1)'(rd_data.cov_cross) + (PROD_W+1)'(rd_data.cov_vel));
        p11_n = sat32((PROD_W+1)'(rd_data.cov_vel) + (PROD_W+1)'({1'b0, r_q}));
        pix_x = to_pixels(px_n);
        pix_y = to_pixels(py_n);
    end

    // Multiplier operands for each step.
    logic signed [MUL_W-1:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_GAIN_POS:  begin mul_a = MUL_W'(r_p00); mul_b = MUL_W'(64'sd1 <<< COV_FRAC_BITS); end
            OP_GAIN_VEL:  begin mul_a = MUL_W'(r_p01); mul_b = MUL_W'(64'sd1 <<< COV_FRAC_BITS); end
            OP_COV_POS:   begin mul_a = MUL_W'(r_p00); mul_b = $signed({3'b000, r_r}); end
            OP_COV_CROSS: begin mul_a = MUL_W'(r_p01); mul_b = $signed({3'b000, r_r}); end
            OP_COV_VEL:   begin mul_a = MUL_W'(r_p01); mul_b = MUL_W'(r_p01); end
            OP_POS_X:     begin mul_a = MUL_W'(r_k0);  mul_b = r_ex; end
            OP_VEL_X:     begin mul_a = MUL_W'(r_k1);  mul_b = r_ex; end
            OP_POS_Y:     begin mul_a = MUL_W'(r_k0);  mul_b = r_ey; end
            OP_VEL_Y:     begin mul_a = MUL_W'(r_k1);  mul_b = r_ey; end
            default: ;
        endcase
    end

    // State update: truncate the gain product toward zero, then add.
    logic signed [PROD_W-1:0] acc_adj;
    logic signed [PROD_W:0]   acc_sum;
    logic signed [WORD_W-1:0] acc_base, acc_res;
    logic signed [WORD_W-1:0] quot_res;
    logic signed [WORD_W+1:0] cv_diff;

    always_comb begin
        case (r_op)
            OP_POS_X: acc_base = r_px;
            OP_VEL_X: acc_base = r_vx;
            OP_POS_Y: acc_base = r_py;
            default:  acc_base = r_vy;
        endcase
        acc_adj = r_prod + (prod_neg ? ((PROD_W'(1) <<< COV_FRAC_BITS) - PROD_W'(1))
                                     : PROD_W'(0));
        acc_sum = (PROD_W+1)'(acc_adj >>> COV_FRAC_BITS) + (PROD_W+1)'(acc_base);
        acc_res = sat32(acc_sum);
        quot_res = quot_sat(div_quot, div_ovf, prod_neg);
        cv_diff  = (WORD_W+2)'(r_p11) - $signed({2'b00, div_quot});
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_idx <= i_in.landmark_index;
            r_oor <= {2'b00, i_in.landmark_index} >= 9'(LANDMARKS);
            r_mx  <= i_in.meas_x;
            r_my  <= i_in.meas_y;
        end
        if (r_state == ST_PRED && out_free && !r_oor) begin
            r_px  <= px_n;
            r_py  <= py_n;
            r_p00 <= p00_n;
            r_p01 <= p01_n;
            r_p11 <= p11_n;
            r_wpx <= px_n;
            r_wpy <= py_n;
            r_vx  <= rd_data.vel_x;
            r_vy  <= rd_data.vel_y;
            r_c00 <= p00_n;
            r_c01 <= p01_n;
            r_c11 <= p11_n;
            r_s   <= WORD_W'({p00_n[WORD_W-1], p00_n} + {2'b00, r_r});
            r_ex  <= (MUL_W'(r_mx) <<< POS_FRAC) - MUL_W'(px_n);
            r_ey  <= (MUL_W'(r_my) <<< POS_FRAC) - MUL_W'(py_n);
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == ST_WAIT && !div_busy) begin
            case (r_op)
                OP_GAIN_POS:  r_k0  <= quot_res;
                OP_GAIN_VEL:  r_k1  <= quot_res;
                OP_COV_POS:   r_c00 <= quot_res;
                OP_COV_CROSS: r_c01 <= quot_res;
                default: begin
                    if (div_ovf) begin
                        r_c11 <= S32_MIN;
                    end else begin
                        r_c11 <= sat32((PROD_W+1)'(cv_diff));
                    end
                end
            endcase
        end
        if (r_state == ST_ACC) begin
            case (r_op)
                OP_POS_X: r_wpx <= acc_res;
                OP_VEL_X: r_vx  <= acc_res;
                OP_POS_Y: r_wpy <= acc_res;
                default:  r_vy  <= acc_res;
            endcase
        end
    end

    // Step counter through the correction sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_GAIN_POS;
        end else if (r_state == ST_PRED) begin
            r_op <= OP_GAIN_POS;
        end else if ((r_state == ST_WAIT && !div_busy) || r_state == ST_ACC) begin
            if (r_op != OP_VEL_Y) begin
                r_op <= t_op'(r_op + 4'd1);
            end
        end
    end

    // Result register: loaded when the prediction is made, held until transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_PRED && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PRED && out_free) begin
            r_oidx <= r_idx;
            r_opx  <= r_oor ? '0 : pix_x;
            r_opy  <= r_oor ? '0 : pix_y;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_index = r_oidx;
    assign o_out.pred_x    = r_opx;
    assign o_out.pred_y    = r_opy;
endmodule
`default_nettype wire

[dv/landmark_kalman_tracker_tb.sv]
// Self-checking testbench for landmark_kalman_tracker: drives measurements, predicts each
// landmark's filter state and checks every predicted point in order.
// Depends on lkt_pkg, lkt_in_if, lkt_out_if and the tracker RTL.
`timescale 1ns / 100ps
module landmark_kalman_tracker_tb
    import lkt_pkg::*;
();

    localparam int NUM_TRACKS = 68;
    localparam int FRAC = 24;
    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [NOISE_W-1:0] i_cfg_data = '0;

    lkt_in_if  meas_ch();
    lkt_out_if point_ch();

    landmark_kalman_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(meas_ch.sink), .o_out(point_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic signed [PRED_W-1:0] px;
        logic signed [PRED_W-1:0] py;
    } t_point;

    // Predictor copy of the tracks and noise registers.
    longint trk_px[NUM_TRACKS], trk_py[NUM_TRACKS], trk_vx[NUM_TRACKS], trk_vy[NUM_TRACKS];
    longint trk_p00[NUM_TRACKS], trk_p01[NUM_TRACKS], trk_p11[NUM_TRACKS];
    longint q_noise, r_noise;
    t_point expected_points[$];

    int errors = 0;
    int points_seen = 0;
    int items_sent = 0;
    int idle_pct = 9;
    bit hold_sink = 1'b0;
    int quiet_cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [PRED_W-1:0] to_pixels(longint p);
        longint w = p / 65536;
        if (w > 16383) w = 16383;
        if (w < -16384) w = -16384;
        return w[PRED_W-1:0];
    endfunction

    // Predict then correct one track; returns the predicted point.
    function automatic t_point track_update(logic [IDX_W-1:0] idx,
                                            logic signed [MEAS_W-1:0] mx,
                                            logic signed [MEAS_W-1:0] my);
        t_point pt;
        longint ppx, ppy, p00, p01, p11, s, k0, k1, ex, ey, one;
        int i;
        one = longint'(1) << FRAC;
        pt.idx = idx;
        pt.px = '0;
        pt.py = '0;
        if (idx >= NUM_TRACKS) return pt;
        i = idx;
        ppx = clamp32(trk_px[i] + trk_vx[i]);
        ppy = clamp32(trk_py[i] + trk_vy[i]);
        p00 = clamp32(trk_p00[i] + 2 * trk_p01[i] + trk_p11[i] + q_noise);
        p01 = clamp32(trk_p01[i] + trk_p11[i]);
        p11 = clamp32(trk_p11[i] + q_noise);
        pt.px = to_pixels(ppx);
        pt.py = to_pixels(ppy);
        trk_px[i] = ppx; trk_py[i] = ppy;
        trk_p00[i] = p00; trk_p01[i] = p01; trk_p11[i] = p11;
        s = p00 + r_noise;
        if (s <= 0) return pt;
        k0 = clamp32((p00 * one) / s);
        k1 = clamp32((p01 * one) / s);
        ex = longint'(mx) * 65536 - ppx;
        ey = longint'(my) * 65536 - ppy;
        trk_px[i] = clamp32(ppx + (k0 * ex) / one);
        trk_vx[i] = clamp32(trk_vx[i] + (k1 * ex) / one);
        trk_py[i] = clamp32(ppy + (k0 * ey) / one);
        trk_vy[i] = clamp32(trk_vy[i] + (k1 * ey) / one);
        trk_p00[i] = clamp32((p00 * r_noise) / s);
        trk_p01[i] = clamp32((p01 * r_noise) / s);
        trk_p11[i] = clamp32(p11 - (p01 * p01) / s);
        return pt;
    endfunction

    // Reset state of the predictor copy.
    task automatic reset_model();
        q_noise = 168;
        r_noise = 1677722;
        for (int i = 0; i < NUM_TRACKS; i++) begin
            trk_px[i] = 0; trk_py[i] = 0; trk_vx[i] = 0; trk_vy[i] = 0;
            trk_p00[i] = 64'sd1 << FRAC; trk_p01[i] = 0; trk_p11[i] = 64'sd1 << FRAC;
        end
    endtask

    // Sink side: random ready, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_sink) begin
            point_ch.ready <= 1'b0;
        end else begin
            point_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare each output transfer with the oldest expected point.
    always @(posedge i_clk) begin
        if (i_rst_n && point_ch.valid && point_ch.ready) begin
            t_point want;
            points_seen++;
            if (expected_points.size() == 0) begin
                $error("unexpected point: index %0d", point_ch.out_index);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (point_ch.out_index !== want.idx) begin
                    $error("out_index: expected %0d actual %0d", want.idx, point_ch.out_index);
                    errors++;
                end
                if (point_ch.pred_x !== want.px) begin
                    $error("pred_x: expected %0d actual %0d", want.px, point_ch.pred_x);
                    errors++;
                end
                if (point_ch.pred_y !== want.py) begin
                    $error("pred_y: expected %0d actual %0d", want.py, point_ch.pred_y);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither channel makes a transfer.
    always @(posedge i_clk) begin
        if ((meas_ch.valid && meas_ch.ready) || (point_ch.valid && point_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL landmark_kalman_tracker");
            $finish;
        end
    end

    // Offer one measurement, with optional random idle cycles before it.
    // Valid stays high afterwards so transfers can follow back to back.
    task automatic send_meas(logic [IDX_W-1:0] idx, logic signed [MEAS_W-1:0] mx,
                             logic signed [MEAS_W-1:0] my);
        t_point pt;
        while ($urandom_range(99) < idle_pct) begin
            meas_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        meas_ch.valid <= 1'b1;
        meas_ch.landmark_index <= idx;
        meas_ch.meas_x <= mx;
        meas_ch.meas_y <= my;
        @(posedge i_clk);
        while (!meas_ch.ready) @(posedge i_clk);
        pt = track_update(idx, mx, my);
        expected_points = {expected_points, pt};
        items_sent++;
    endtask

    task automatic wait_drained();
        meas_ch.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_noise(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PROCESS_NOISE) q_noise = val;
        else if (idx == CFG_MEASURE_NOISE) r_noise = val;
        @(posedge i_clk);
    endtask

    function automatic logic signed [MEAS_W-1:0] rand_meas();
        return MEAS_W'($urandom_range(12287) - 4096);
    endfunction

    // Field extremes, out-of-range indexes and repeated hits on tracks 0, 1 and 2.
    task automatic test_directed();
        send_meas(7'd0, 14'sd8191, -14'sd4096);
        send_meas(7'd67, -14'sd4096, 14'sd8191);
        send_meas(7'd68, 14'sd100, 14'sd100);
        send_meas(7'd127, -14'sd1, 14'sd1);
        send_meas(7'd0, 14'sd8191, -14'sd4096);
        send_meas(7'd0, -14'sd4096, 14'sd8191);
        send_meas(7'd0, 14'sd0, 14'sd0);
        send_meas(7'd1, 14'sd5461, -14'sd2731);
        send_meas(7'd1, -14'sd1366, 14'sd2730);
        for (int k = 0; k < 6; k++) send_meas(7'd2, 14'sd1000 + 14'(k * 50), -14'sd300);
        wait_drained();
    endtask

    // Random tracks that follow a smooth path with some jumps and junk indexes.
    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            int sel = $urandom_range(99);
            logic [IDX_W-1:0] idx;
            if (sel < 5) idx = IDX_W'($urandom_range(127, 68));
            else if (sel < 50) idx = IDX_W'($urandom_range(7));
            else idx = IDX_W'($urandom_range(67));
            if (sel < 80) begin
                send_meas(idx, 14'(200 + 3 * n + $urandom_range(4)),
                          14'(-100 - 2 * n + $urandom_range(4)));
            end else begin
                send_meas(idx, rand_meas(), rand_meas());
            end
        end
        wait_drained();
    endtask

    // Noise extremes: zero Q and R, largest Q and R; S can overflow or go nonpositive.
    task automatic test_noise_settings();
        write_noise(CFG_PROCESS_NOISE, '0);
        write_noise(CFG_MEASURE_NOISE, '0);
        test_random(40);
        write_noise(CFG_PROCESS_NOISE, 31'h7FFF_FFFF);
        write_noise(CFG_MEASURE_NOISE, 31'h7FFF_FFFF);
        test_random(40);
        write_noise(CFG_PROCESS_NOISE, 31'h7FFF_FFFF);
        write_noise(CFG_MEASURE_NOISE, 31'd1);
        test_random(30);
        write_noise(CFG_UNUSED_IDX, 31'h1234_5678);
        write_noise(CFG_PROCESS_NOISE, NOISE_W'($urandom));
        write_noise(CFG_MEASURE_NOISE, NOISE_W'($urandom));
        test_random(30);
        write_noise(CFG_PROCESS_NOISE, 31'd168);
        write_noise(CFG_MEASURE_NOISE, 31'd1677722);
    endtask

    // Stop the sink for a long stretch while measurements keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            test_random(20);
        join
    endtask

    initial begin
        reset_model();
        meas_ch.valid = 1'b0;
        meas_ch.landmark_index = '0;
        meas_ch.meas_x = '0;
        meas_ch.meas_y = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_pct = 0;
        test_random(80);
        idle_pct = 9;
        test_random(320);
        test_backpressure();
        test_noise_settings();
        test_random(40);
        wait_drained();
        $display("Covered %0d measurements and %0d predicted points,", items_sent, points_seen);
        $display("including noise extremes, invalid indexes and a long output stall.");
        if (errors == 0) begin
            $display("PASS landmark_kalman_tracker");
        end else begin
            $display("FAIL landmark_kalman_tracker");
        end
        $finish;
    end
endmodule

[files.f]
hdl/lkt_pkg.sv
hdl/lkt_in_if.sv
hdl/lkt_out_if.sv
hdl/lkt_track_mem.sv
hdl/lkt_divider.sv
hdl/landmark_kalman_tracker.sv
dv/landmark_kalman_tracker_tb.sv
